[hw/rtl/moi_pkg.sv]
`timescale 1ns / 1ps
// moi_pkg: shared constants, command types and divisor tables of the odometry integrator
// no dependencies

package moi_pkg;

    localparam int COUNT_BITS = 32;
    localparam int SUM_W      = COUNT_BITS + 3;
    localparam int POSE_W     = 40;
    localparam int WIDE_A_W   = 48;
    localparam int ACC_W      = 80;
    localparam int STEP_W     = 50;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_COUNT  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGN_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN      = 2'd2;

    localparam logic [3:0]  SIGN_MASK_RST = 4'd9;
    localparam logic [31:0] DIST_RST      = 32'd33427847;
    localparam logic [31:0] TURN_RST      = 32'd3284089;

    localparam logic [30:0] Q30_ONE        = 31'h4000_0000;
    localparam logic [31:0] QUARTER_PI_Q32 = 32'd3373259426;

    localparam logic [3:0] SIN_LAST  = 4'd4;
    localparam logic [3:0] COS_FIRST = 4'd5;
    localparam logic [3:0] COS_LAST  = 4'd10;

    // floor(x / d) = (x * M) >> K for every x below 2^30
    localparam logic [5:0] DIV_K [DIV_COUNT] = '{
        6'd37, 6'd37, 6'd36, 6'd35, 6'd33,
        6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd31
    };

    localparam logic [31:0] DIV_M [DIV_COUNT] = '{
        32'(((64'd1 << 37) + 64'd109) / 64'd110),
        32'(((64'd1 << 37) + 64'd71) / 64'd72),
        32'(((64'd1 << 36) + 64'd41) / 64'd42),
        32'(((64'd1 << 35) + 64'd19) / 64'd20),
        32'(((64'd1 << 33) + 64'd5) / 64'd6),
        32'(((64'd1 << 38) + 64'd131) / 64'd132),
        32'(((64'd1 << 37) + 64'd89) / 64'd90),
        32'(((64'd1 << 36) + 64'd55) / 64'd56),
        32'(((64'd1 << 35) + 64'd29) / 64'd30),
        32'(((64'd1 << 34) + 64'd11) / 64'd12),
        32'(((64'd1 << 31) + 64'd1) / 64'd2)
    };

    typedef enum logic [2:0] {
        MS_FQ,
        MS_RR,
        MS_R2T,
        MS_XM,
        MS_RT,
        MS_WLO,
        MS_WHI
    } msel_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_IN,
        WB_R,
        WB_R2,
        WB_X,
        WB_T,
        WB_S0,
        WB_SC,
        WB_LD,
        WB_ACC_LO,
        WB_ACC_HI,
        WB_ROUND,
        WB_POS,
        WB_OUT
    } wb_t;

    typedef enum logic [2:0] {
        W_BX,
        W_BY,
        W_CX,
        W_SY,
        W_SX,
        W_CY,
        W_H
    } wide_t;

    typedef struct packed {
        msel_t      msel;
        wb_t        wb;
        wide_t      wsel;
        logic [3:0] div_idx;
    } cmd_t;

endpackage

[hw/rtl/moi_if.sv]
`timescale 1ns / 1ps
// moi_if: channel interfaces for encoder totals, pose results and register writes
// depends on moi_pkg

interface moi_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [moi_pkg::COUNT_BITS-1:0] count_wheel_a;
    logic signed [moi_pkg::COUNT_BITS-1:0] count_wheel_b;
    logic signed [moi_pkg::COUNT_BITS-1:0] count_wheel_c;
    logic signed [moi_pkg::COUNT_BITS-1:0] count_wheel_d;

    modport source (output valid, count_wheel_a, count_wheel_b, count_wheel_c, count_wheel_d,
                    input ready);
    modport sink (input valid, count_wheel_a, count_wheel_b, count_wheel_c, count_wheel_d,
                  output ready);
endinterface

interface moi_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [moi_pkg::POSE_W-1:0] pose_x;
    logic signed [moi_pkg::POSE_W-1:0] pose_y;
    logic        [moi_pkg::POSE_W-1:0] pose_heading;

    modport source (output valid, pose_x, pose_y, pose_heading, input ready);
    modport sink (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface moi_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [moi_pkg::CFG_IDX_W-1:0]      index;
    logic [moi_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/mecanum_odometry_integrator.sv]
`timescale 1ns / 1ps
// Mecanum wheel dead-reckoning odometry integrator. Each transaction on odo_in
// carries the four wheel encoder totals; the block differences them against the
// previous totals, applies the per-wheel signs and the mecanum patterns, rotates
// the body step by the heading held before the update and returns one pose
// transaction (x, y in metres with 24 fraction bits, saturating; heading as a
// 40-bit binary angle). Every term of the sine/cosine series and every wide
// product passes in turn through the single shared 32x32 multiplier, and new
// totals are not taken while an update runs. A finished pose waits in an
// output register, so the next totals can be taken while it is unread.
// Register writes on cfg are accepted at once and belong in idle periods.
// depends on moi_pkg, moi_if, moi_ctrl and moi_dpath

module mecanum_odometry_integrator (
    input  logic       clk,
    input  logic       rst_n,
    moi_in_if.sink     odo_in,
    moi_out_if.source  pose_out,
    moi_cfg_if.sink    cfg
);

    moi_pkg::cmd_t                        cmd;
    logic [3:0][moi_pkg::COUNT_BITS-1:0]  counts;

    assign counts = {odo_in.count_wheel_d, odo_in.count_wheel_c,
                     odo_in.count_wheel_b, odo_in.count_wheel_a};

    moi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (odo_in.valid),
        .in_ready  (odo_in.ready),
        .out_valid (pose_out.valid),
        .out_ready (pose_out.ready),
        .cmd       (cmd)
    );

    moi_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .counts       (counts),
        .pose_x       (pose_out.pose_x),
        .pose_y       (pose_out.pose_y),
        .pose_heading (pose_out.pose_heading)
    );

endmodule

[hw/rtl/moi_ctrl.sv]
`timescale 1ns / 1ps
// moi_ctrl: sequencer that steps the datapath through one odometry update
// depends on moi_pkg

module moi_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output moi_pkg::cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANGLE,
        S_SIN,
        S_SINF,
        S_COS,
        S_SC,
        S_WIDE,
        S_POS,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [3:0]      idx_reg, idx_next;
    logic [2:0]      ph_reg, ph_next;
    moi_pkg::wide_t  wsel_reg, wsel_next;
    logic            in_ready_reg, in_ready_next;
    logic            out_valid_reg, out_valid_next;

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        ph_next        = ph_reg;
        wsel_next      = wsel_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        cmd.msel       = moi_pkg::MS_FQ;
        cmd.wb         = moi_pkg::WB_NONE;
        cmd.wsel       = wsel_reg;
        cmd.div_idx    = idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.wb        = moi_pkg::WB_IN;
                    in_ready_next = 1'b0;
                    ph_next       = 3'd0;
                    state_next    = S_ANGLE;
                end
            end
            S_ANGLE:
            begin
                ph_next = ph_reg + 3'd1;
                unique case (ph_reg[1:0])
                    2'd0: cmd.msel = moi_pkg::MS_FQ;
                    2'd1: cmd.wb   = moi_pkg::WB_R;
                    2'd2: cmd.msel = moi_pkg::MS_RR;
                    default:
                    begin
                        cmd.wb     = moi_pkg::WB_R2;
                        ph_next    = 3'd0;
                        idx_next   = 4'd0;
                        state_next = S_SIN;
                    end
                endcase
            end
            S_SIN, S_COS:
            begin
                ph_next = ph_reg + 3'd1;
                unique case (ph_reg[1:0])
                    2'd0: cmd.msel = moi_pkg::MS_R2T;
                    2'd1: cmd.wb   = moi_pkg::WB_X;
                    2'd2: cmd.msel = moi_pkg::MS_XM;
                    default:
                    begin
                        cmd.wb  = moi_pkg::WB_T;
                        ph_next = 3'd0;
                        idx_next = idx_reg + 4'd1;
                        if (state_reg == S_SIN && idx_reg == moi_pkg::SIN_LAST)
                        begin
                            state_next = S_SINF;
                        end
                        else if (state_reg == S_COS && idx_reg == moi_pkg::COS_LAST)
                        begin
                            state_next = S_SC;
                        end
                    end
                endcase
            end
            S_SINF:
            begin
                if (ph_reg == 3'd0)
                begin
                    cmd.msel = moi_pkg::MS_RT;
                    ph_next  = 3'd1;
                end
                else
                begin
                    cmd.wb     = moi_pkg::WB_S0;
                    ph_next    = 3'd0;
                    idx_next   = moi_pkg::COS_FIRST;
                    state_next = S_COS;
                end
            end
            S_SC:
            begin
                cmd.wb     = moi_pkg::WB_SC;
                ph_next    = 3'd0;
                wsel_next  = moi_pkg::W_BX;
                state_next = S_WIDE;
            end
            S_WIDE:
            begin
                ph_next = ph_reg + 3'd1;
                unique case (ph_reg)
                    3'd0: cmd.wb = moi_pkg::WB_LD;
                    3'd1: cmd.msel = moi_pkg::MS_WLO;
                    3'd2:
                    begin
                        cmd.msel = moi_pkg::MS_WHI;
                        cmd.wb   = moi_pkg::WB_ACC_LO;
                    end
                    3'd3: cmd.wb = moi_pkg::WB_ACC_HI;
                    default:
                    begin
                        cmd.wb  = moi_pkg::WB_ROUND;
                        ph_next = 3'd0;
                        if (wsel_reg == moi_pkg::W_H)
                        begin
                            state_next = S_POS;
                        end
                        else
                        begin
                            wsel_next = moi_pkg::wide_t'(wsel_reg + 3'd1);
                        end
                    end
                endcase
            end
            S_POS:
            begin
                cmd.wb     = moi_pkg::WB_POS;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.wb         = moi_pkg::WB_OUT;
                    out_valid_next = 1'b1;
                    in_ready_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 4'd0;
            ph_reg        <= 3'd0;
            wsel_reg      <= moi_pkg::W_BX;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ph_reg        <= ph_next;
            wsel_reg      <= wsel_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready_reg) |=> !in_ready_reg)
        else $error("second transaction taken while an update runs");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> state_reg == S_OUT)
        else $error("pending result overwritten");

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready_reg |-> (state_reg == S_IDLE && !out_valid_next) || state_reg == S_IDLE)
        else $error("ready raised outside idle");

    a_wide_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WIDE |-> ph_reg <= 3'd4)
        else $error("wide product phase out of range");
`endif

endmodule

[hw/rtl/moi_dpath.sv]
`timescale 1ns / 1ps
// moi_dpath: registers, shared 32x32 multiplier and arithmetic of the odometry update
// depends on moi_pkg and moi_if

module moi_dpath (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  moi_pkg::cmd_t                          cmd,
    moi_cfg_if.sink                                cfg,
    input  logic [3:0][moi_pkg::COUNT_BITS-1:0]    counts,
    output logic signed [moi_pkg::POSE_W-1:0]      pose_x,
    output logic signed [moi_pkg::POSE_W-1:0]      pose_y,
    output logic        [moi_pkg::POSE_W-1:0]      pose_heading
);

    localparam int CB = moi_pkg::COUNT_BITS;
    localparam int SW = moi_pkg::SUM_W;
    localparam int PW = moi_pkg::POSE_W;
    localparam int AW = moi_pkg::WIDE_A_W;
    localparam int XW = moi_pkg::ACC_W;
    localparam int DW = moi_pkg::STEP_W;

    logic [3:0]            mask_reg;
    logic [31:0]           dist_reg;
    logic [31:0]           turn_reg;
    logic [CB-1:0]         prev_reg [4];
    logic signed [PW-1:0]  pos_x_reg, pos_x_next;
    logic signed [PW-1:0]  pos_y_reg, pos_y_next;
    logic [PW-1:0]         heading_reg;

    logic signed [SW-1:0]  fwd_reg, str_reg, rot_reg;
    logic [31:0]           f_reg;
    logic [2:0]            oct_reg;
    logic [29:0]           r_reg, r2_reg, x_reg, s0_reg;
    logic [30:0]           t_reg;
    logic signed [31:0]    sn_reg, cs_reg;
    logic [AW-1:0]         wa_reg;
    logic [31:0]           wm_reg;
    logic                  neg_reg;
    logic [XW-1:0]         acc_reg;
    logic signed [DW-1:0]  bx_reg, by_reg, dsx_reg, dsy_reg;
    logic [63:0]           prod_reg;
    logic signed [PW-1:0]  out_x_reg, out_y_reg;
    logic [PW-1:0]         out_h_reg;

    logic [CB-1:0]         diff [4];
    logic signed [SW-1:0]  delta [4];
    logic signed [SW-1:0]  fwd_new, str_new, rot_new;
    logic [37:0]           fold;
    logic [31:0]           mul_a, mul_b;
    logic [63:0]           quo_wide;
    logic [30:0]           su, cu;
    logic signed [31:0]    sn_new, cs_new;
    logic [SW-1:0]         fwd_mag, str_mag, rot_mag;
    logic [DW-1:0]         bx_mag, by_mag;
    logic [31:0]           sn_mag, cs_mag;
    logic [AW-1:0]         ld_wa;
    logic [31:0]           ld_wm;
    logic                  ld_neg;
    logic [XW-1:0]         acc_r18, acc_r30;
    logic [DW-2:0]         rnd_mag;
    logic signed [DW-1:0]  rnd;
    logic signed [DW:0]    sum_x, sum_y;

    assign cfg.ready    = 1'b1;
    assign pose_x       = out_x_reg;
    assign pose_y       = out_y_reg;
    assign pose_heading = out_h_reg;

    // wheel deltas and kinematic patterns
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            diff[i]  = counts[i] - prev_reg[i];
            delta[i] = mask_reg[i] ? -SW'(signed'(diff[i])) : SW'(signed'(diff[i]));
        end
        fwd_new = delta[0] + delta[1] + delta[2] + delta[3];
        str_new = delta[0] - delta[1] + delta[2] - delta[3];
        rot_new = delta[0] - delta[1] - delta[2] + delta[3];
    end

    // octant folding of the current heading
    assign fold = heading_reg[37] ? ((38'd1 << 37) - {1'b0, heading_reg[36:0]})
                                  : {1'b0, heading_reg[36:0]};

    always_comb
    begin
        unique case (cmd.msel)
            moi_pkg::MS_FQ:
            begin
                mul_a = f_reg;
                mul_b = moi_pkg::QUARTER_PI_Q32;
            end
            moi_pkg::MS_RR:
            begin
                mul_a = {2'b0, r_reg};
                mul_b = {2'b0, r_reg};
            end
            moi_pkg::MS_R2T:
            begin
                mul_a = {2'b0, r2_reg};
                mul_b = {1'b0, t_reg};
            end
            moi_pkg::MS_XM:
            begin
                mul_a = {2'b0, x_reg};
                mul_b = moi_pkg::DIV_M[cmd.div_idx];
            end
            moi_pkg::MS_RT:
            begin
                mul_a = {2'b0, r_reg};
                mul_b = {1'b0, t_reg};
            end
            moi_pkg::MS_WLO:
            begin
                mul_a = wa_reg[31:0];
                mul_b = wm_reg;
            end
            moi_pkg::MS_WHI:
            begin
                mul_a = {16'b0, wa_reg[AW-1:32]};
                mul_b = wm_reg;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign quo_wide = prod_reg >> moi_pkg::DIV_K[cmd.div_idx];

    // quadrant mapping of the octant sine and cosine
    always_comb
    begin
        su = oct_reg[0] ? t_reg : {1'b0, s0_reg};
        cu = oct_reg[0] ? {1'b0, s0_reg} : t_reg;
        unique case (oct_reg[2:1])
            2'd0:
            begin
                sn_new = 32'(su);
                cs_new = 32'(cu);
            end
            2'd1:
            begin
                sn_new = 32'(cu);
                cs_new = -32'(su);
            end
            2'd2:
            begin
                sn_new = -32'(su);
                cs_new = -32'(cu);
            end
            default:
            begin
                sn_new = -32'(cu);
                cs_new = 32'(su);
            end
        endcase
    end

    assign fwd_mag = fwd_reg[SW-1] ? SW'(-fwd_reg) : SW'(fwd_reg);
    assign str_mag = str_reg[SW-1] ? SW'(-str_reg) : SW'(str_reg);
    assign rot_mag = rot_reg[SW-1] ? SW'(-rot_reg) : SW'(rot_reg);
    assign bx_mag  = bx_reg[DW-1] ? DW'(-bx_reg) : DW'(bx_reg);
    assign by_mag  = by_reg[DW-1] ? DW'(-by_reg) : DW'(by_reg);
    assign sn_mag  = sn_reg[31] ? 32'(-sn_reg) : 32'(sn_reg);
    assign cs_mag  = cs_reg[31] ? 32'(-cs_reg) : 32'(cs_reg);

    // operands of the signed wide products (rounded, except the heading term)
    always_comb
    begin
        unique case (cmd.wsel)
            moi_pkg::W_BX:
            begin
                ld_wa  = AW'(fwd_mag);
                ld_wm  = dist_reg;
                ld_neg = fwd_reg[SW-1];
            end
            moi_pkg::W_BY:
            begin
                ld_wa  = AW'(str_mag);
                ld_wm  = dist_reg;
                ld_neg = str_reg[SW-1];
            end
            moi_pkg::W_CX:
            begin
                ld_wa  = bx_mag[AW-1:0];
                ld_wm  = cs_mag;
                ld_neg = cs_reg[31] ^ bx_reg[DW-1];
            end
            moi_pkg::W_SY:
            begin
                ld_wa  = by_mag[AW-1:0];
                ld_wm  = sn_mag;
                ld_neg = sn_reg[31] ^ by_reg[DW-1];
            end
            moi_pkg::W_SX:
            begin
                ld_wa  = bx_mag[AW-1:0];
                ld_wm  = sn_mag;
                ld_neg = sn_reg[31] ^ bx_reg[DW-1];
            end
            moi_pkg::W_CY:
            begin
                ld_wa  = by_mag[AW-1:0];
                ld_wm  = cs_mag;
                ld_neg = cs_reg[31] ^ by_reg[DW-1];
            end
            default:
            begin
                ld_wa  = AW'(rot_mag);
                ld_wm  = turn_reg;
                ld_neg = rot_reg[SW-1];
            end
        endcase
    end

    // round half away from zero on the magnitude
    assign acc_r18 = acc_reg + (XW'(1) << 17);
    assign acc_r30 = acc_reg + (XW'(1) << 29);
    assign rnd_mag = (cmd.wsel == moi_pkg::W_BX || cmd.wsel == moi_pkg::W_BY)
                   ? acc_r18[18 +: DW-1] : acc_r30[30 +: DW-1];
    assign rnd     = neg_reg ? -{1'b0, rnd_mag} : {1'b0, rnd_mag};

    // saturating position update
    assign sum_x = (DW+1)'(pos_x_reg) + (DW+1)'(dsx_reg);
    assign sum_y = (DW+1)'(pos_y_reg) + (DW+1)'(dsy_reg);

    always_comb
    begin
        if (sum_x[DW:PW-1] == '0 || sum_x[DW:PW-1] == '1)
        begin
            pos_x_next = sum_x[PW-1:0];
        end
        else
        begin
            pos_x_next = {sum_x[DW], {(PW-1){~sum_x[DW]}}};
        end
        if (sum_y[DW:PW-1] == '0 || sum_y[DW:PW-1] == '1)
        begin
            pos_y_next = sum_y[PW-1:0];
        end
        else
        begin
            pos_y_next = {sum_y[DW], {(PW-1){~sum_y[DW]}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= moi_pkg::SIGN_MASK_RST;
            dist_reg    <= moi_pkg::DIST_RST;
            turn_reg    <= moi_pkg::TURN_RST;
            for (int i = 0; i < 4; i++)
            begin
                prev_reg[i] <= '0;
            end
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    moi_pkg::CFG_SIGN_MASK: mask_reg <= cfg.data[3:0];
                    moi_pkg::CFG_DIST:      dist_reg <= cfg.data;
                    moi_pkg::CFG_TURN:      turn_reg <= cfg.data;
                    default:                ;
                endcase
            end
            if (cmd.wb == moi_pkg::WB_IN)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    prev_reg[i] <= counts[i];
                end
            end
            if (cmd.wb == moi_pkg::WB_POS)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
            if (cmd.wb == moi_pkg::WB_ROUND && cmd.wsel == moi_pkg::W_H)
            begin
                heading_reg <= neg_reg ? heading_reg - acc_reg[PW-1:0]
                                       : heading_reg + acc_reg[PW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (cmd.wb)
            moi_pkg::WB_IN:
            begin
                fwd_reg <= fwd_new;
                str_reg <= str_new;
                rot_reg <= rot_new;
                f_reg   <= fold[37:6];
                oct_reg <= heading_reg[39:37];
            end
            moi_pkg::WB_R: r_reg <= prod_reg[62:33];
            moi_pkg::WB_R2:
            begin
                r2_reg <= prod_reg[59:30];
                t_reg  <= moi_pkg::Q30_ONE;
            end
            moi_pkg::WB_X: x_reg <= prod_reg[59:30];
            moi_pkg::WB_T: t_reg <= moi_pkg::Q30_ONE - quo_wide[30:0];
            moi_pkg::WB_S0:
            begin
                s0_reg <= prod_reg[59:30];
                t_reg  <= moi_pkg::Q30_ONE;
            end
            moi_pkg::WB_SC:
            begin
                sn_reg <= sn_new;
                cs_reg <= cs_new;
            end
            moi_pkg::WB_LD:
            begin
                wa_reg  <= ld_wa;
                wm_reg  <= ld_wm;
                neg_reg <= ld_neg;
            end
            moi_pkg::WB_ACC_LO: acc_reg <= XW'(prod_reg);
            moi_pkg::WB_ACC_HI: acc_reg <= acc_reg + {prod_reg[XW-33:0], 32'b0};
            moi_pkg::WB_ROUND:
            begin
                unique case (cmd.wsel)
                    moi_pkg::W_BX: bx_reg  <= rnd;
                    moi_pkg::W_BY: by_reg  <= rnd;
                    moi_pkg::W_CX: dsx_reg <= rnd;
                    moi_pkg::W_SY: dsx_reg <= dsx_reg - rnd;
                    moi_pkg::W_SX: dsy_reg <= rnd;
                    moi_pkg::W_CY: dsy_reg <= dsy_reg + rnd;
                    default:       ;
                endcase
            end
            moi_pkg::WB_OUT:
            begin
                out_x_reg <= pos_x_reg;
                out_y_reg <= pos_y_reg;
                out_h_reg <= heading_reg;
            end
            default: ;
        endcase
    end

endmodule

[dv/moi_scoreboard.sv]
`timescale 1ns / 1ps
// moi_scoreboard: pose predictor and result checker for the odometry integrator test
// depends on moi_pkg

class moi_pose_tracker;
    bit [3:0]         sign_mask;
    bit [31:0]        travel;
    bit [31:0]        turn;
    bit [31:0]        last_count [4];
    longint           pos_x;
    longint           pos_y;
    bit [39:0]        heading;
    bit [119:0]       pending_poses [$];
    int               mismatches;

    function void clear();
        sign_mask = moi_pkg::SIGN_MASK_RST;
        travel = moi_pkg::DIST_RST;
        turn = moi_pkg::TURN_RST;
        foreach (last_count[i]) last_count[i] = '0;
        pos_x = 0;
        pos_y = 0;
        heading = '0;
        pending_poses.delete();
        mismatches = 0;
    endfunction

    function void write_reg(logic [moi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        if (idx == moi_pkg::CFG_SIGN_MASK) sign_mask = value[3:0];
        else if (idx == moi_pkg::CFG_DIST) travel = value;
        else if (idx == moi_pkg::CFG_TURN) turn = value;
    endfunction

    // round(a*b / 2^sh), ties away from zero, clipped to a 63-bit magnitude
    function longint round_mul(longint a, longint b, int sh);
        logic [127:0] ua, ub, p;
        logic [127:0] m;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? 128'(-a) : 128'(a);
        ub = b < 0 ? 128'(-b) : 128'(b);
        if (a == 64'sh8000000000000000) ua = 128'h8000000000000000;
        if (b == 64'sh8000000000000000) ub = 128'h8000000000000000;
        p = ua * ub;
        m = (p + (128'd1 << (sh - 1))) >> sh;
        if (m > 128'h7FFFFFFFFFFFFFFF) m = 128'h7FFFFFFFFFFFFFFF;
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function void series(longint r, output longint s, output longint c);
        longint sdiv [5] = '{110, 72, 42, 20, 6};
        longint cdiv [6] = '{132, 90, 56, 30, 12, 2};
        longint r2, t;
        longint one;
        one = 64'd1 << 30;
        r2 = (r * r) >>> 30;
        t = one;
        for (int i = 0; i < 5; i++) t = one - ((r2 * t) >>> 30) / sdiv[i];
        s = (r * t) >>> 30;
        t = one;
        for (int i = 0; i < 6; i++) t = one - ((r2 * t) >>> 30) / cdiv[i];
        c = t;
    endfunction

    function void heading_trig(bit [39:0] h, output longint s, output longint c);
        bit [2:0] oct;
        bit [63:0] f;
        bit [95:0] prod;
        longint s0, c0, su, cu;
        oct = h[39:37];
        f = {27'd0, h[36:0]};
        if (oct[0]) f = (64'd1 << 37) - f;
        f = f >> 6;
        prod = f * 96'(moi_pkg::QUARTER_PI_Q32);
        series(longint'(prod >> 33), s0, c0);
        if (oct[0]) begin su = c0; cu = s0; end
        else begin su = s0; cu = c0; end
        case (oct[2:1])
            2'd0: begin s = su; c = cu; end
            2'd1: begin s = cu; c = -su; end
            2'd2: begin s = -su; c = -cu; end
            default: begin s = -cu; c = su; end
        endcase
    endfunction

    function longint clip40(longint v);
        if (v > 64'sd549755813887) return 64'sd549755813887;
        if (v < -64'sd549755813888) return -64'sd549755813888;
        return v;
    endfunction

    function void note_counts(bit [31:0] cnt [4]);
        longint d [4];
        longint fwd, strafe, rot, bx, by, sn, cs, dx, dy;
        bit [31:0] diff;
        for (int i = 0; i < 4; i++) begin
            diff = cnt[i] - last_count[i];
            last_count[i] = cnt[i];
            d[i] = longint'(signed'(diff));
            if (sign_mask[i]) d[i] = -d[i];
        end
        fwd = d[0] + d[1] + d[2] + d[3];
        strafe = d[0] - d[1] + d[2] - d[3];
        rot = d[0] - d[1] - d[2] + d[3];
        bx = round_mul(fwd, longint'(travel), 18);
        by = round_mul(strafe, longint'(travel), 18);
        heading_trig(heading, sn, cs);
        dx = round_mul(cs, bx, 30) - round_mul(sn, by, 30);
        dy = round_mul(sn, bx, 30) + round_mul(cs, by, 30);
        pos_x = clip40(pos_x + dx);
        pos_y = clip40(pos_y + dy);
        heading = heading + 40'(rot * longint'(turn));
        pending_poses.push_back({pos_x[39:0], pos_y[39:0], heading});
    endfunction

    function void check_pose(bit [39:0] x, bit [39:0] y, bit [39:0] h);
        bit [119:0] want;
        if (pending_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected pose transaction x=%h y=%h h=%h", x, y, h);
            return;
        end
        want = pending_poses.pop_front();
        if (want != {x, y, h}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("pose mismatch: expected x=%h y=%h h=%h, got x=%h y=%h h=%h",
                         want[119:80], want[79:40], want[39:0], x, y, h);
        end
    endfunction
endclass

[dv/mecanum_odometry_integrator_test.sv]
`timescale 1ns / 1ps
// mecanum_odometry_integrator_test: random and directed encoder totals, checked pose by pose
// depends on moi_pkg, moi_if, moi_scoreboard and the integrator rtl

module mecanum_odometry_integrator_test;

    localparam logic [moi_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;
    int   quiet_cycles;
    bit   timed_out;
    bit [31:0] totals [4];

    moi_in_if  odo_in ();
    moi_out_if pose_out ();
    moi_cfg_if cfg ();

    moi_pose_tracker pose_model;

    mecanum_odometry_integrator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .odo_in   (odo_in.sink),
        .pose_out (pose_out.source),
        .cfg      (cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver with random stalls and an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            pose_out.ready <= 1'b0;
        end
        else
            pose_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (pose_out.valid && pose_out.ready && rst_n)
            pose_model.check_pose(pose_out.pose_x, pose_out.pose_y, pose_out.pose_heading);
    end

    always @(posedge clk)
    begin
        if ((odo_in.valid && odo_in.ready) || (pose_out.valid && pose_out.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [moi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        pose_model.write_reg(idx, value);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_totals(bit [31:0] a, bit [31:0] b, bit [31:0] c, bit [31:0] d);
        bit [31:0] cnt [4];
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        cnt = '{a, b, c, d};
        odo_in.valid <= 1'b1;
        odo_in.count_wheel_a <= a;
        odo_in.count_wheel_b <= b;
        odo_in.count_wheel_c <= c;
        odo_in.count_wheel_d <= d;
        do @(posedge clk); while (!odo_in.ready);
        pose_model.note_counts(cnt);
        totals = cnt;
        odo_in.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pose_model.pending_poses.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // mostly small moves from the current totals, sometimes wild jumps
    task automatic random_step();
        bit [31:0] n [4];
        int spread;
        spread = $urandom_range(3) == 0 ? 100000 : 400;
        for (int i = 0; i < 4; i++)
            n[i] = $urandom_range(15) == 0 ? $urandom()
                 : totals[i] + 32'($signed($urandom_range(2 * spread)) - spread);
        send_totals(n[0], n[1], n[2], n[3]);
    endtask

    initial
    begin
        pose_model = new();
        pose_model.clear();
        rst_n = 1'b0;
        odo_in.valid = 1'b0;
        odo_in.count_wheel_a = '0;
        odo_in.count_wheel_b = '0;
        odo_in.count_wheel_c = '0;
        odo_in.count_wheel_d = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        pose_out.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        totals = '{0, 0, 0, 0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, first step against zero, extremes, counter wrap
        send_totals(32'd100, 32'd50, 32'd25, 32'd10);
        send_totals(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'd0);
        send_totals(32'h80000000, 32'h7FFFFFFF, 32'd0, 32'hFFFFFFFF);
        send_totals(32'h80000005, 32'h7FFFFFF0, 32'd3, 32'h00000002);
        send_totals(32'h80000005, 32'h7FFFFFF0, 32'd3, 32'h00000002);
        drain();
        write_reg(moi_pkg::CFG_SIGN_MASK, 32'hFFFFFFF0);
        write_reg(moi_pkg::CFG_DIST, 32'hFFFFFFFF);
        write_reg(moi_pkg::CFG_TURN, 32'hFFFFFFFF);
        write_reg(CFG_UNMAPPED, 32'h12345678);
        send_totals(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_totals(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        // drive into saturation
        for (int i = 0; i < 6; i++)
            send_totals(totals[0] + 32'h7FFFFFFF, totals[1] + 32'h7FFFFFFF,
                        totals[2] + 32'h7FFFFFFF, totals[3] + 32'h7FFFFFFF);
        for (int i = 0; i < 6; i++)
            send_totals(totals[0] - 32'h7FFFFFFF, totals[1] + 32'h7FFFFFFF,
                        totals[2] - 32'h7FFFFFFF, totals[3] + 32'h7FFFFFFF);
        drain();
        write_reg(moi_pkg::CFG_SIGN_MASK, 32'd15);
        write_reg(moi_pkg::CFG_DIST, 32'd0);
        write_reg(moi_pkg::CFG_TURN, 32'd0);
        send_totals(32'd1, 32'd2, 32'd3, 32'd4);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(moi_pkg::CFG_SIGN_MASK, $urandom_range(15));
            write_reg(moi_pkg::CFG_DIST,
                      phase == 0 ? moi_pkg::DIST_RST : $urandom_range(200000000));
            write_reg(moi_pkg::CFG_TURN, phase == 3 ? $urandom() : $urandom_range(50000000));
            send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 53 : 27) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 53 : 27) : 0;
            if (phase == 0) hold_off = 600;
            for (int i = 0; i < 145; i++) random_step();
            drain();
        end

        if (pose_model.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
